### hw/rtl/pss_pkg.sv
// Package for the 2-D particle swarm step block.
// Holds item structs, codes, queue sizing and saturation helpers; no dependencies.
`timescale 1ns / 1ps
package pss_pkg;

  localparam int SWARM_SIZE_DEFAULT = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int DRAW_MAX = 1000;
  localparam int DIVISOR = 1000;
  localparam int DIV_W = 45;
  localparam int DIV_MAG_W = 44;
  localparam int DIV_REM_W = 10;
  localparam int DIV_CHUNK_W = 22;
  localparam int DIV_RECIP_SHIFT = 38;
  localparam logic [28:0] DIV_RECIP = 29'd274877907;
  localparam logic [17:0] INERTIA_START_RESET = 18'd65536;
  localparam logic [16:0] INERTIA_DECAY_RESET = 17'd64881;
  localparam logic REG_INERTIA_START = 1'b0;
  localparam logic REG_INERTIA_DECAY = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD      = 2'd0,
    CMD_UPDATE    = 2'd1,
    CMD_END_ROUND = 2'd2,
    CMD_UNUSED    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_UPDATE,
    OP_END_ROUND,
    OP_ZERO
  } op_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [2:0]         index;
    logic signed [31:0] load_x;
    logic signed [31:0] load_y;
    logic [9:0]         draw_self_x;
    logic [9:0]         draw_swarm_x;
    logic [9:0]         draw_self_y;
    logic [9:0]         draw_swarm_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic [31:0]        out_cost;
    logic [2:0]         best_slot;
  } out_item_t;

  typedef struct packed {
    op_e                op;
    logic [2:0]         slot;
    logic signed [31:0] load_x;
    logic signed [31:0] load_y;
    logic [1:0][9:0]    r_self;
    logic [1:0][9:0]    r_swarm;
  } job_t;

  typedef struct packed {
    logic        we;
    logic        idx;
    logic [17:0] data;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD,
    ST_M_INER,
    ST_M_SELF,
    ST_DIV1,
    ST_WAIT1,
    ST_DIV2,
    ST_WAIT2,
    ST_AXIS,
    ST_COST_X,
    ST_COST_Y,
    ST_COST_SUM,
    ST_COMMIT,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_GB_RD,
    ST_GB_SET
  } state_e;

  function automatic logic [31:0] sat32(input logic signed [35:0] v);
    logic [31:0] r;
    if ((v[35:31] == 5'b00000) || (v[35:31] == 5'b11111)) begin
      r = v[31:0];
    end else if (v[35]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

  function automatic logic [9:0] clamp_draw(input logic [9:0] d);
    logic [9:0] r;
    r = (d > 10'(DRAW_MAX)) ? 10'(DRAW_MAX) : d;
    return r;
  endfunction

endpackage

### hw/rtl/pss_front.sv
// Front end: classifies an incoming command into a job and clamps the draws.
// Depends on pss_pkg.
`timescale 1ns / 1ps
module pss_front import pss_pkg::*; #(
  parameter int SWARM_SIZE = SWARM_SIZE_DEFAULT
) (
  input  in_item_t item_i,
  output job_t     job_o
);

  logic in_range;

  always_comb begin
    in_range = ({29'b0, item_i.index} < 32'(SWARM_SIZE));
    job_o.slot = item_i.index;
    job_o.load_x = item_i.load_x;
    job_o.load_y = item_i.load_y;
    job_o.r_self[0] = clamp_draw(item_i.draw_self_x);
    job_o.r_self[1] = clamp_draw(item_i.draw_self_y);
    job_o.r_swarm[0] = clamp_draw(item_i.draw_swarm_x);
    job_o.r_swarm[1] = clamp_draw(item_i.draw_swarm_y);
    case (cmd_e'(item_i.command))
      CMD_LOAD: begin
        job_o.op = in_range ? OP_LOAD : OP_ZERO;
      end
      CMD_UPDATE: begin
        job_o.op = in_range ? OP_UPDATE : OP_ZERO;
      end
      CMD_END_ROUND: begin
        job_o.op = OP_END_ROUND;
      end
      default: begin
        job_o.op = OP_ZERO;
        job_o.slot = 3'd0;
      end
    endcase
  end

endmodule

### hw/rtl/pss_queue.sv
// Short job queue between front and back end.
// Depends on pss_pkg.
`timescale 1ns / 1ps
module pss_queue import pss_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t head_o,
  output logic empty_o,
  output logic full_o
);

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QPTR_W:0]   cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i) rptr_q <= rptr_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= job_i;
  end

endmodule

### hw/rtl/pss_cdiv.sv
// Floor division of a signed product by the draw scale, two 22-bit digits,
// each by reciprocal multiply; done_o marks the quotient ready. Depends on pss_pkg.
`timescale 1ns / 1ps
module pss_cdiv import pss_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DIV_W-1:0] dividend_i,
  output logic                    done_o,
  output logic signed [DIV_W-1:0] quot_o
);

  logic                   busy_q, done_q, neg_q;
  logic [1:0]             step_q;
  logic [DIV_CHUNK_W-1:0] lo_q, qhi_q, qlo_q, qdig;
  logic [31:0]            v_q, rfull;
  logic [60:0]            prod_q;
  logic [DIV_REM_W-1:0]   rem_q, rdig;
  logic [DIV_W-1:0]       abs_in, qpos;

  always_comb begin
    abs_in = dividend_i[DIV_W-1] ? (DIV_W)'(-dividend_i) : dividend_i;
    qdig = prod_q[DIV_RECIP_SHIFT +: DIV_CHUNK_W];
    rfull = v_q - (32'(qdig) * 32'(DIVISOR));
    rdig = rfull[DIV_REM_W-1:0];
    qpos = {1'b0, qhi_q, qlo_q};
    if (neg_q) begin
      quot_o = -$signed(qpos) - $signed({{(DIV_W-1){1'b0}}, (rem_q != '0)});
    end else begin
      quot_o = $signed(qpos);
    end
  end

  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && (step_q == 2'd3);
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd3) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DIV_W-1];
      lo_q  <= abs_in[DIV_CHUNK_W-1:0];
      v_q   <= {{(32-DIV_CHUNK_W){1'b0}}, abs_in[DIV_MAG_W-1:DIV_CHUNK_W]};
    end else if (busy_q) begin
      case (step_q)
        2'd0, 2'd2: begin
          prod_q <= {29'd0, v_q} * {32'd0, DIV_RECIP};
        end
        2'd1: begin
          qhi_q <= qdig;
          v_q   <= {rdig, lo_q};
        end
        default: begin
          qlo_q <= qdig;
          rem_q <= rdig;
        end
      endcase
    end
  end

endmodule

### hw/rtl/pss_back.sv
// Back end: swarm state memories, sequencer, shared multiplier and result register.
// Depends on pss_pkg and pss_cdiv.
`timescale 1ns / 1ps
module pss_back import pss_pkg::*; #(
  parameter int SWARM_SIZE = SWARM_SIZE_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  job_t      head_i,
  input  logic      empty_i,
  output logic      pop_o,
  output logic      valid_o,
  output out_item_t result_o
);

  localparam int AW = (SWARM_SIZE > 1) ? $clog2(SWARM_SIZE) : 1;

  state_e state_q, state_d;
  job_t   cur_q;

  logic [63:0] pos_mem [SWARM_SIZE];
  logic [63:0] vel_mem [SWARM_SIZE];
  logic [63:0] pb_mem  [SWARM_SIZE];
  logic [31:0] pbc_mem [SWARM_SIZE];
  logic [31:0] cc_mem  [SWARM_SIZE];
  logic [63:0] pos_rd, vel_rd, pb_rd;
  logic [31:0] pbc_rd, cc_rd;
  logic [AW-1:0] raddr, waddr;
  logic          wr_main, wr_pb;
  logic [63:0]   vel_wdata;

  logic signed [31:0] x_q [2];
  logic signed [31:0] v_q [2];
  logic signed [31:0] pb_q [2];
  logic signed [31:0] gb_q [2];
  logic [31:0]        pbc_q, cost_q, best_q;
  logic [47:0]        cs_q;
  logic signed [35:0] acc_q;
  logic               axis_q;
  logic [AW-1:0]      cnt_q, win_q;
  logic [17:0]        start_q, inertia_q;
  logic [16:0]        decay_q;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] p_q;
  logic               div_start, div_done;
  logic signed [DIV_W-1:0] quot;
  logic               emit;
  out_item_t          res_d, res_q;
  logic               valid_q;
  logic [31:0]        nv, nx;
  logic [48:0]        csum;
  logic [19:0]        idec;
  logic signed [31:0] x_cur, v_cur, pb_cur, gb_cur;
  logic [9:0]         r1_cur, r2_cur;

  pss_cdiv u_cdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (p_q[DIV_W-1:0]),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_comb begin
    x_cur  = x_q[axis_q];
    v_cur  = v_q[axis_q];
    pb_cur = pb_q[axis_q];
    gb_cur = gb_q[axis_q];
    r1_cur = cur_q.r_self[axis_q];
    r2_cur = cur_q.r_swarm[axis_q];
    nv = sat32(acc_q);
    nx = sat32({{4{x_cur[31]}}, x_cur} + {{4{nv[31]}}, nv});
    csum = {1'b0, cs_q} + {1'b0, p_q[63:16]};
    idec = p_q[35:16];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          case (head_i.op)
            OP_LOAD:      state_d = ST_COST_X;
            OP_UPDATE:    state_d = ST_RD;
            OP_END_ROUND: state_d = ST_SCAN_RD;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_RD:       state_d = ST_M_INER;
      ST_M_INER:   state_d = ST_M_SELF;
      ST_M_SELF:   state_d = ST_DIV1;
      ST_DIV1:     state_d = ST_WAIT1;
      ST_WAIT1:    if (div_done) state_d = ST_DIV2;
      ST_DIV2:     state_d = ST_WAIT2;
      ST_WAIT2:    if (div_done) state_d = ST_AXIS;
      ST_AXIS:     state_d = axis_q ? ST_COST_X : ST_M_INER;
      ST_COST_X:   state_d = ST_COST_Y;
      ST_COST_Y:   state_d = ST_COST_SUM;
      ST_COST_SUM: state_d = ST_COMMIT;
      ST_COMMIT:   state_d = ST_IDLE;
      ST_SCAN_RD:  state_d = ST_SCAN_CMP;
      ST_SCAN_CMP: state_d = (cnt_q == AW'(SWARM_SIZE - 1)) ? ST_GB_RD : ST_SCAN_RD;
      ST_GB_RD:    state_d = ST_GB_SET;
      ST_GB_SET:   state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o = 1'b0;
    raddr = AW'(cur_q.slot);
    waddr = AW'(cur_q.slot);
    wr_main = 1'b0;
    wr_pb = 1'b0;
    vel_wdata = (cur_q.op == OP_LOAD) ? 64'd0 : {v_q[1], v_q[0]};
    mul_a = '0;
    mul_b = '0;
    div_start = 1'b0;
    emit = 1'b0;
    res_d = '0;
    case (state_q)
      ST_IDLE: begin
        raddr = AW'(head_i.slot);
        pop_o = !empty_i;
        if (!empty_i && (head_i.op == OP_ZERO)) begin
          emit = 1'b1;
          res_d.best_slot = head_i.slot;
        end
      end
      ST_M_INER: begin
        mul_a = {v_cur[31], v_cur};
        mul_b = {15'd0, inertia_q};
      end
      ST_M_SELF: begin
        mul_a = {pb_cur[31], pb_cur} - {x_cur[31], x_cur};
        mul_b = {22'd0, r1_cur, 1'b0};
      end
      ST_DIV1, ST_DIV2: begin
        div_start = 1'b1;
      end
      ST_WAIT1: begin
        mul_a = {gb_cur[31], gb_cur} - {x_cur[31], x_cur};
        mul_b = {22'd0, r2_cur, 1'b0};
      end
      ST_COST_X: begin
        mul_a = {x_q[0][31], x_q[0]};
        mul_b = {x_q[0][31], x_q[0]};
      end
      ST_COST_Y: begin
        mul_a = {x_q[1][31], x_q[1]};
        mul_b = {x_q[1][31], x_q[1]};
      end
      ST_COMMIT: begin
        wr_main = 1'b1;
        wr_pb = (cur_q.op == OP_LOAD) || (cost_q < pbc_q);
        emit = 1'b1;
        res_d.out_x = x_q[0];
        res_d.out_y = x_q[1];
        res_d.out_cost = cost_q;
        res_d.best_slot = cur_q.slot;
      end
      ST_SCAN_RD: begin
        raddr = cnt_q;
      end
      ST_GB_RD: begin
        raddr = win_q;
        mul_a = {15'd0, inertia_q};
        mul_b = {16'd0, decay_q};
      end
      ST_GB_SET: begin
        emit = 1'b1;
        res_d.out_x = pos_rd[31:0];
        res_d.out_y = pos_rd[63:32];
        res_d.out_cost = best_q;
        res_d.best_slot = 3'(win_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    pos_rd <= pos_mem[raddr];
    vel_rd <= vel_mem[raddr];
    pb_rd  <= pb_mem[raddr];
    pbc_rd <= pbc_mem[raddr];
    cc_rd  <= cc_mem[raddr];
    if (wr_main) begin
      pos_mem[waddr] <= {x_q[1], x_q[0]};
      vel_mem[waddr] <= vel_wdata;
      cc_mem[waddr]  <= cost_q;
    end
    if (wr_pb) begin
      pb_mem[waddr]  <= {x_q[1], x_q[0]};
      pbc_mem[waddr] <= cost_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
    if (emit) res_q <= res_d;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          cur_q <= head_i;
          x_q[0] <= head_i.load_x;
          x_q[1] <= head_i.load_y;
          cnt_q <= '0;
        end
      end
      ST_RD: begin
        x_q[0]  <= pos_rd[31:0];
        x_q[1]  <= pos_rd[63:32];
        v_q[0]  <= vel_rd[31:0];
        v_q[1]  <= vel_rd[63:32];
        pb_q[0] <= pb_rd[31:0];
        pb_q[1] <= pb_rd[63:32];
        pbc_q   <= pbc_rd;
        axis_q  <= 1'b0;
      end
      ST_M_SELF: acc_q <= p_q[51:16];
      ST_WAIT1, ST_WAIT2: begin
        if (div_done) acc_q <= acc_q + quot[35:0];
      end
      ST_AXIS: begin
        v_q[axis_q] <= nv;
        x_q[axis_q] <= nx;
        axis_q <= 1'b1;
      end
      ST_COST_Y: cs_q <= p_q[63:16];
      ST_COST_SUM: cost_q <= (|csum[48:32]) ? 32'hFFFF_FFFF : csum[31:0];
      ST_SCAN_CMP: begin
        if ((cnt_q == '0) || (cc_rd < best_q)) begin
          best_q <= cc_rd;
          win_q <= cnt_q;
        end
        cnt_q <= cnt_q + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      valid_q   <= 1'b0;
      gb_q[0]   <= '0;
      gb_q[1]   <= '0;
      start_q   <= INERTIA_START_RESET;
      inertia_q <= INERTIA_START_RESET;
      decay_q   <= INERTIA_DECAY_RESET;
    end else begin
      state_q <= state_d;
      valid_q <= emit;
      if (state_q == ST_GB_SET) begin
        gb_q[0] <= pos_rd[31:0];
        gb_q[1] <= pos_rd[63:32];
        inertia_q <= (|idec[19:18]) ? 18'h3FFFF : idec[17:0];
      end
      if (cfg_i.we) begin
        if (cfg_i.idx == REG_INERTIA_START) begin
          start_q   <= cfg_i.data;
          inertia_q <= cfg_i.data;
        end else if (cfg_i.idx == REG_INERTIA_DECAY) begin
          decay_q <= cfg_i.data[16:0];
        end
      end
    end
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

  a_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (state_q == ST_IDLE))
    else $error("result emitted outside a finishing step");

  a_div_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_WAIT1) || (state_q == ST_WAIT2)) && !div_done
    |=> (state_q == $past(state_q)))
    else $error("left division wait early");

  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> !div_done)
    else $error("division finished too soon");

  a_start_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_i.we && (cfg_i.idx == REG_INERTIA_START)) |=> (inertia_q == start_q))
    else $error("inertia not reloaded");

endmodule

### hw/rtl/particle_swarm_step_2d.sv
// Particle swarm step: one result per command, one cycle strobe, no stall from receiver.
// An update command runs four floor divisions by 1000, two per axis.
// Throughput: one command in flight in the back end, two more queued; busy while full.
// Reset: async active low; inertia and global best reset, slot memories not cleared.
`timescale 1ns / 1ps
module particle_swarm_step_2d import pss_pkg::*; #(
  parameter int SWARM_SIZE = SWARM_SIZE_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_i,
  output logic        result_valid_o,
  output out_item_t   result_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [17:0] cfg_wdata_i
);

  job_t job, head;
  logic empty, full, pop, push;
  cfg_t cfg;

  assign busy = full;
  assign push = start && !full;
  assign cfg = '{we: cfg_we_i, idx: cfg_index_i, data: cfg_wdata_i};

  pss_front #(.SWARM_SIZE(SWARM_SIZE)) u_front (
    .item_i (in_i),
    .job_o  (job)
  );

  pss_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  pss_back #(.SWARM_SIZE(SWARM_SIZE)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .head_i   (head),
    .empty_i  (empty),
    .pop_o    (pop),
    .valid_o  (result_valid_o),
    .result_o (result_o)
  );

endmodule
